>>> rtl/tcc_pkg.sv
// Shared definitions for the text console cursor engine.
// Widths, opcodes, character codes, register map and the controller/datapath
// command and status bundles. No dependencies.
package tcc_pkg;

  // field widths
  localparam int unsigned CELL_W = 14;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned USED_W = 15;
  localparam int unsigned OP_W   = 2;

  // default geometry
  localparam int unsigned SCREEN_COLS_DEF  = 80;
  localparam int unsigned SCREEN_CELLS_DEF = 2000;
  localparam int unsigned BUFFER_CELLS_DEF = 16384;

  // cursor comes out of reset at the start of this row
  localparam int unsigned RESET_ROW = 5;

  // opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_GET   = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // configuration register map
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_ATTR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_USED = 2'd2;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
  localparam logic [CELL_W-1:0] BASE_RESET = '0;
  localparam logic [USED_W-1:0] USED_RESET = 15'd16384;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture the accepted command
    logic exec;      // apply the command to cursor and cell fields
    logic div_step;  // row number of the cursor offset
    logic nl_fix;    // move cursor to the next row start
    logic scroll;    // test / step the display start
    logic out_load;  // load the result register
  } tcc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ex_div;     // newline needs the row number
    logic scroll_go;  // display start must advance one row
  } tcc_status_t;

endpackage

>>> rtl/tcc_dp.sv
// Datapath of the text console cursor engine: cursor and start registers,
// cell write fields, row number by reciprocal multiply, row-step scroll and result register.
// Depends on tcc_pkg.
module tcc_dp #(
  parameter int unsigned SCREEN_COLS  = tcc_pkg::SCREEN_COLS_DEF,
  parameter int unsigned SCREEN_CELLS = tcc_pkg::SCREEN_CELLS_DEF,
  parameter int unsigned BUFFER_CELLS = tcc_pkg::BUFFER_CELLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcc_pkg::tcc_cmd_t           cmd_i,
  output tcc_pkg::tcc_status_t        status_o,
  input  logic [tcc_pkg::OP_W-1:0]    opcode_i,
  input  logic [tcc_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcc_pkg::CELL_W-1:0]  position_i,
  input  logic [tcc_pkg::ATTR_W-1:0]  char_attribute_i,
  input  logic [tcc_pkg::CELL_W-1:0]  buffer_base_cell_i,
  input  logic [tcc_pkg::USED_W-1:0]  buffer_cells_used_i,
  output logic                        cell_write_valid_o,
  output logic [tcc_pkg::CELL_W-1:0]  cell_index_o,
  output logic [tcc_pkg::CHAR_W-1:0]  cell_char_o,
  output logic [tcc_pkg::ATTR_W-1:0]  cell_attr_o,
  output logic [tcc_pkg::CELL_W-1:0]  cursor_reg_o,
  output logic [tcc_pkg::CELL_W-1:0]  start_reg_o,
  output logic                        clear_request_o
);

  localparam int unsigned CW = tcc_pkg::CELL_W;
  // wide enough for every sum the scroll loop and buffer end can reach
  localparam int unsigned CALC_W = $clog2(BUFFER_CELLS + SCREEN_CELLS + 2 * SCREEN_COLS
                                          + 3 * (2 ** CW));
  // offset / SCREEN_COLS = (offset * RECIP) >> DIV_SH, exact for every 14-bit offset
  localparam int unsigned DIV_SH  = CW + $clog2(SCREEN_COLS);
  localparam int unsigned RECIP_W = CW + 1;
  localparam int unsigned PROD_W  = CW + RECIP_W;
  localparam int unsigned QUO_W   = PROD_W - DIV_SH;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_SH) + SCREEN_COLS - 1) / SCREEN_COLS);
  localparam logic [CALC_W-1:0] COLS_X  = CALC_W'(SCREEN_COLS);
  localparam logic [CALC_W-1:0] CELLS_X = CALC_W'(SCREEN_CELLS);
  localparam logic [CALC_W-1:0] BUFEND_X = CALC_W'(BUFFER_CELLS);
  localparam logic [CW-1:0]     CUR_RESET = CW'(SCREEN_COLS * tcc_pkg::RESET_ROW);

  // latched command
  logic [tcc_pkg::OP_W-1:0]   op_q;
  logic [tcc_pkg::CHAR_W-1:0] ch_q;
  logic [CW-1:0]              pos_q;

  // architectural state
  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] start_q, start_d;

  // work registers
  logic [CALC_W-1:0] st_work_q, st_work_d;
  logic [CW-1:0]     off_q, off_d;
  logic [QUO_W-1:0]  quo_q, quo_d;

  // cell write fields
  logic                      wv_q, wv_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [tcc_pkg::CHAR_W-1:0] wch_q, wch_d;
  logic [tcc_pkg::ATTR_W-1:0] wat_q, wat_d;
  logic                      clr_q, clr_d;

  // execute-phase results
  logic [CW-1:0]              ex_cur, ex_start, ex_idx;
  logic                       ex_wv, ex_clr, ex_div;
  logic [tcc_pkg::CHAR_W-1:0] ex_ch;
  logic [tcc_pkg::ATTR_W-1:0] ex_at;

  logic [CALC_W-1:0] base_x, cur_x, end_sum, end_x;
  logic [CALC_W-1:0] fix_x, scr_st, scr_lim;
  logic [CW-1:0]     cur_fix, scr_cur, cur_dec, cur_inc;
  logic              scr_cond;
  logic [PROD_W-1:0] prod;

  assign base_x  = CALC_W'(buffer_base_cell_i);
  assign cur_x   = CALC_W'(cursor_q);
  assign end_sum = base_x + CALC_W'(buffer_cells_used_i);
  assign end_x   = (end_sum > BUFEND_X) ? BUFEND_X : end_sum;
  assign cur_dec = cursor_q - 1'b1;
  assign cur_inc = cursor_q + 1'b1;

  always_comb begin
    ex_cur   = cursor_q;
    ex_start = start_q;
    ex_wv    = 1'b0;
    ex_idx   = '0;
    ex_ch    = '0;
    ex_at    = '0;
    ex_clr   = 1'b0;
    ex_div   = 1'b0;
    unique case (op_q)
      tcc_pkg::OP_WRITE: begin
        if (ch_q == tcc_pkg::CH_NEWLINE) begin
          if (cur_x + COLS_X < end_x) begin
            ex_wv  = 1'b1;
            ex_idx = cursor_q;
            ex_ch  = tcc_pkg::CH_NEWLINE;
            if (cursor_q < buffer_base_cell_i) begin
              ex_cur = buffer_base_cell_i;
            end else begin
              ex_div = 1'b1;
            end
          end
        end else if (ch_q == tcc_pkg::CH_BACKSPACE) begin
          if (cursor_q > buffer_base_cell_i) begin
            ex_cur = cur_dec;
            ex_wv  = 1'b1;
            ex_idx = cur_dec;
            ex_ch  = tcc_pkg::CH_SPACE;
            ex_at  = char_attribute_i;
          end
        end else begin
          if (cur_x + CALC_W'(1) < end_x) begin
            ex_wv  = 1'b1;
            ex_idx = cursor_q;
            ex_ch  = ch_q;
            ex_at  = char_attribute_i;
            ex_cur = cur_inc;
          end
        end
      end
      tcc_pkg::OP_SET: begin
        ex_cur = pos_q;
      end
      tcc_pkg::OP_CLEAR: begin
        ex_cur   = buffer_base_cell_i;
        ex_start = buffer_base_cell_i;
        ex_clr   = 1'b1;
      end
      tcc_pkg::OP_GET: begin
        ex_cur = cursor_q;
      end
      default: begin
        ex_cur = cursor_q;
      end
    endcase
  end

  // row number of the offset from the base
  assign prod = PROD_W'(off_q) * PROD_W'(RECIP);

  // next row start: base + cols * (row + 1)
  assign fix_x   = base_x + (CALC_W'(quo_q) + CALC_W'(1)) * COLS_X;
  assign cur_fix = fix_x[CW-1:0];

  // scroll test against whichever cursor and start the phase holds
  always_comb begin
    if (cmd_i.exec) begin
      scr_cur = ex_cur;
    end else if (cmd_i.nl_fix) begin
      scr_cur = cur_fix;
    end else begin
      scr_cur = cursor_q;
    end
  end
  assign scr_st   = cmd_i.scroll ? st_work_q : CALC_W'(start_q);
  assign scr_lim  = scr_st + CELLS_X;
  assign scr_cond = (CALC_W'(scr_cur) >= scr_lim) && (scr_lim < end_x);

  assign status_o.ex_div    = ex_div;
  assign status_o.scroll_go = scr_cond &&
                              (!cmd_i.exec || ((op_q == tcc_pkg::OP_WRITE) && !ex_div));

  always_comb begin
    cursor_d  = cursor_q;
    start_d   = start_q;
    st_work_d = st_work_q;
    off_d     = off_q;
    quo_d     = quo_q;
    wv_d      = wv_q;
    idx_d     = idx_q;
    wch_d     = wch_q;
    wat_d     = wat_q;
    clr_d     = clr_q;
    if (cmd_i.exec) begin
      cursor_d = ex_cur;
      start_d  = ex_start;
      wv_d     = ex_wv;
      idx_d    = ex_idx;
      wch_d    = ex_ch;
      wat_d    = ex_at;
      clr_d    = ex_clr;
      off_d    = cursor_q - buffer_base_cell_i;
    end
    if (cmd_i.div_step) begin
      quo_d = prod[PROD_W-1:DIV_SH];
    end
    if (cmd_i.nl_fix) begin
      cursor_d = cur_fix;
    end
    if ((cmd_i.exec || cmd_i.nl_fix || cmd_i.scroll) && scr_cond) begin
      st_work_d = scr_st + COLS_X;
    end
    if (cmd_i.scroll && !scr_cond) begin
      start_d = st_work_q[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= CUR_RESET;
      start_q  <= '0;
    end else begin
      cursor_q <= cursor_d;
      start_q  <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      ch_q  <= char_code_i;
      pos_q <= position_i;
    end
    st_work_q <= st_work_d;
    off_q     <= off_d;
    quo_q     <= quo_d;
    wv_q      <= wv_d;
    idx_q     <= idx_d;
    wch_q     <= wch_d;
    wat_q     <= wat_d;
    clr_q     <= clr_d;
    if (cmd_i.out_load) begin
      cell_write_valid_o <= wv_d;
      cell_index_o       <= idx_d;
      cell_char_o        <= wch_d;
      cell_attr_o        <= wat_d;
      cursor_reg_o       <= cursor_d;
      start_reg_o        <= start_d;
      clear_request_o    <= clr_d;
    end
  end

endmodule

>>> rtl/tcc_ctrl.sv
// Controller of the text console cursor engine: command sequencing,
// input stall and result valid. Depends on tcc_pkg.
module tcc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  tcc_pkg::tcc_status_t  status_i,
  output tcc_pkg::tcc_cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_NLFIX  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       fin, slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    fin     = 1'b0;
    unique case (state_q) inside
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.ex_div) begin
          state_d = S_DIV;
        end else if (status_i.scroll_go) begin
          state_d = S_SCROLL;
        end else begin
          fin = 1'b1;
        end
      end
      S_DIV: begin
        state_d = S_NLFIX;
      end
      S_NLFIX, S_SCROLL: begin
        if (status_i.scroll_go) begin
          state_d = S_SCROLL;
        end else begin
          fin = 1'b1;
        end
      end
      S_WAIT: begin
        fin = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      state_d = slot_free ? S_IDLE : S_WAIT;
    end
  end

  assign cmd_o.latch    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec     = (state_q == S_EXEC);
  assign cmd_o.div_step = (state_q == S_DIV);
  assign cmd_o.nl_fix   = (state_q == S_NLFIX);
  assign cmd_o.scroll   = (state_q == S_SCROLL);
  assign cmd_o.out_load = fin && slot_free;

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/text_console_cursor_engine.sv
// Text console cursor engine, top level: configuration registers on an APB-style
// port, controller and datapath. Depends on tcc_pkg, tcc_ctrl and tcc_dp.
//
// Takes console commands (write char, set cursor, clear, get cursor) and returns one
// result per command: the cell write it causes and the cursor and display start
// values afterwards. One command is in flight at a time; a finished result sits in
// the output register so the next command can be taken while it waits. Most commands
// pass through the transfer in and an execute step, after which the result is
// registered and the next command can be taken. A newline that moves to the next
// row adds the row number of the cursor offset by a reciprocal multiply, then the
// row fix-up; every row the display start advances adds a scroll step, since the
// scroll steps one row per cycle through the scroll adders and compares. A full output
// register holds the block in its last step until the result is taken. Configuration
// registers: 0x0 char_attribute, 0x4 buffer_base_cell, 0x8 buffer_cells_used; write
// them only while idle.
module text_console_cursor_engine #(
  parameter int unsigned SCREEN_COLS  = tcc_pkg::SCREEN_COLS_DEF,
  parameter int unsigned SCREEN_CELLS = tcc_pkg::SCREEN_CELLS_DEF,
  parameter int unsigned BUFFER_CELLS = tcc_pkg::BUFFER_CELLS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB-style configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tcc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tcc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tcc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  // command channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tcc_pkg::OP_W-1:0]         opcode_i,
  input  logic [tcc_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tcc_pkg::CELL_W-1:0]       position_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             cell_write_valid_o,
  output logic [tcc_pkg::CELL_W-1:0]       cell_index_o,
  output logic [tcc_pkg::CHAR_W-1:0]       cell_char_o,
  output logic [tcc_pkg::ATTR_W-1:0]       cell_attr_o,
  output logic [tcc_pkg::CELL_W-1:0]       cursor_reg_o,
  output logic [tcc_pkg::CELL_W-1:0]       start_reg_o,
  output logic                             clear_request_o
);

  logic [tcc_pkg::ATTR_W-1:0]    attr_q;
  logic [tcc_pkg::CELL_W-1:0]    base_q;
  logic [tcc_pkg::USED_W-1:0]    used_q;
  logic [tcc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  tcc_pkg::tcc_cmd_t    cmd;
  tcc_pkg::tcc_status_t status;

  // no wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[tcc_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcc_pkg::ATTR_RESET;
      base_q <= tcc_pkg::BASE_RESET;
      used_q <= tcc_pkg::USED_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        tcc_pkg::REG_ATTR: attr_q <= pwdata[tcc_pkg::ATTR_W-1:0];
        tcc_pkg::REG_BASE: base_q <= pwdata[tcc_pkg::CELL_W-1:0];
        tcc_pkg::REG_USED: used_q <= pwdata[tcc_pkg::USED_W-1:0];
        default: begin
          // unmapped: transfer ignored
        end
      endcase
    end
  end

  // read back, unmapped addresses read zero
  always_comb begin
    unique case (reg_idx)
      tcc_pkg::REG_ATTR: prdata = tcc_pkg::APB_DATA_W'(attr_q);
      tcc_pkg::REG_BASE: prdata = tcc_pkg::APB_DATA_W'(base_q);
      tcc_pkg::REG_USED: prdata = tcc_pkg::APB_DATA_W'(used_q);
      default:           prdata = '0;
    endcase
  end

  tcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcc_dp #(
    .SCREEN_COLS  (SCREEN_COLS),
    .SCREEN_CELLS (SCREEN_CELLS),
    .BUFFER_CELLS (BUFFER_CELLS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .opcode_i            (opcode_i),
    .char_code_i         (char_code_i),
    .position_i          (position_i),
    .char_attribute_i    (attr_q),
    .buffer_base_cell_i  (base_q),
    .buffer_cells_used_i (used_q),
    .cell_write_valid_o  (cell_write_valid_o),
    .cell_index_o        (cell_index_o),
    .cell_char_o         (cell_char_o),
    .cell_attr_o         (cell_attr_o),
    .cursor_reg_o        (cursor_reg_o),
    .start_reg_o         (start_reg_o),
    .clear_request_o     (clear_request_o)
  );

endmodule
